/* rtl/core/huber_qc_weight_assert.svh */
// assertion macros for the huber qc weight block
// no dependencies; included by huber_qc_weight.sv, the rtl file that checks itself
`ifndef HUBER_QC_WEIGHT_ASSERT_SVH
`define HUBER_QC_WEIGHT_ASSERT_SVH
`ifndef SYNTHESIS
`define HQW_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hqw assertion failed");
`define HQW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hqw assertion failed");
`else
`define HQW_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define HQW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/hqw_pkg.sv */
// shared types and constants for the huber qc weight block
// no dependencies
package hqw_pkg;
   localparam int DATA_W    = 32;
   localparam int OUT_FRAC  = 16;
   localparam int WEIGHT_W  = OUT_FRAC + 1;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int QUOT_W    = DATA_W + 1;
   localparam int CSR_ADDR_W = 2;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << OUT_FRAC;

   localparam logic [CSR_ADDR_W-1:0] CSR_QC_ENABLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEFT      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RIGHT     = 2'd2;

   typedef struct packed {
      logic one;
      logic zero;
      logic outside;
      logic invalid;
   } hqw_tag_type;
endpackage

/* rtl/core/hqw_if.sv */
// channel interfaces for the huber qc weight block
// depends on hqw_pkg
interface hqw_req_if;
   import hqw_pkg::*;
   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] innovation;
   logic [DATA_W-1:0] error_stddev;
   modport source (output valid, innovation, error_stddev, input ready);
   modport sink (input valid, innovation, error_stddev, output ready);
endinterface

interface hqw_rsp_if;
   import hqw_pkg::*;
   logic valid;
   logic ready;
   logic [WEIGHT_W-1:0] weight_sqrt;
   logic outside_window;
   logic invalid;
   modport source (output valid, weight_sqrt, outside_window, invalid, input ready);
   modport sink (input valid, weight_sqrt, outside_window, invalid, output ready);
endinterface

interface hqw_csr_if;
   import hqw_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [DATA_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

/* rtl/core/hqw_frac_div.sv */
// pipelined restoring divider: q = floor(num * 2^32 / den), num <= den
// depends on hqw_pkg
module hqw_frac_div import hqw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  hqw_tag_type       in_tag,
   input  logic [PROD_W-1:0] in_num,
   input  logic [PROD_W-1:0] in_den,
   output logic              out_valid,
   output hqw_tag_type       out_tag,
   output logic [QUOT_W-1:0] out_q
);
   logic              valid_ff [0:DATA_W];
   hqw_tag_type       tag_ff   [0:DATA_W];
   logic [PROD_W-1:0] rem_ff   [0:DATA_W];
   logic [PROD_W-1:0] den_ff   [0:DATA_W];
   logic [QUOT_W-1:0] q_ff     [0:DATA_W];

   // integer part is one only when num equals den
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         den_ff[0] <= in_den;
         rem_ff[0] <= (in_num == in_den) ? '0 : in_num;
         q_ff[0]   <= {{(QUOT_W-1){1'b0}}, in_num == in_den};
      end
   end

   for (genvar k = 1; k <= DATA_W; k++) begin : g_step
      logic [PROD_W-1:0] shl_in;
      logic              take_in;
      assign shl_in  = rem_ff[k-1] << 1;
      assign take_in = shl_in >= den_ff[k-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[k] <= tag_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            rem_ff[k] <= take_in ? (shl_in - den_ff[k-1]) : shl_in;
            q_ff[k]   <= {q_ff[k-1][QUOT_W-2:0], take_in};
         end
      end
   end

   assign out_valid = valid_ff[DATA_W];
   assign out_tag   = tag_ff[DATA_W];
   assign out_q     = q_ff[DATA_W];
endmodule

/* rtl/core/hqw_isqrt.sv */
// pipelined digit-by-digit square root, floor(sqrt(q)) for q <= 2^32
// depends on hqw_pkg
module hqw_isqrt import hqw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  hqw_tag_type         in_tag,
   input  logic [QUOT_W-1:0]   in_q,
   output logic                out_valid,
   output hqw_tag_type         out_tag,
   output logic [WEIGHT_W-1:0] out_root
);
   localparam int STEPS = WEIGHT_W;
   localparam int SUB_W = 2 * WEIGHT_W + 1;

   logic                valid_ff [0:STEPS];
   hqw_tag_type         tag_ff   [0:STEPS];
   logic [SUB_W-1:0]    rem_ff   [0:STEPS];
   logic [WEIGHT_W-1:0] root_ff  [0:STEPS];

   always_comb begin
      valid_ff[0] = in_valid;
      tag_ff[0]   = in_tag;
      rem_ff[0]   = SUB_W'(in_q);
      root_ff[0]  = '0;
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int B = STEPS - k;
      logic [SUB_W-1:0] sub_in;
      logic             take_in;
      assign sub_in  = (SUB_W'(root_ff[k-1]) << (B + 1)) + (SUB_W'(1) << (2 * B));
      assign take_in = rem_ff[k-1] >= sub_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[k]  <= tag_ff[k-1];
            rem_ff[k]  <= take_in ? (rem_ff[k-1] - sub_in) : rem_ff[k-1];
            root_ff[k] <= take_in ? (root_ff[k-1] | (WEIGHT_W'(1) << B)) : root_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_tag   = tag_ff[STEPS];
   assign out_root  = root_ff[STEPS];
endmodule

/* rtl/core/huber_qc_weight.sv */
// huber qc weight: square root of the huber-norm variational qc weight
// depends on hqw_pkg, hqw_if, hqw_frac_div, hqw_isqrt, huber_qc_weight_assert.svh
//
// usage:
//   req_ch carries innovation (signed q16.16) and error_stddev (unsigned q16.16);
//   a transfer happens when valid and ready are both high.
//   rsp_ch returns one result per request, in order: weight_sqrt (q1.16),
//   outside_window and invalid.
//   csr_ch writes qc_enable (addr 0), left_threshold (addr 1) and
//   right_threshold (addr 2); csr_ch.ready is always high. write only when idle.
// pipeline: a request passes 3 front stages, 33 divider stages, 17 square root
//   stages and the output register before its result is valid.
// throughput: one item per cycle while no stall holds the pipeline; the 32 one-bit
//   divider stages and 17 root stages are fully pipelined.
// reset: synchronous, clears all valid bits and the csr registers (qc off,
//   thresholds zero).
// stall: when rsp_ch.ready is low with a result waiting, the whole pipeline
//   holds and req_ch.ready drops; nothing is lost or repeated.
module huber_qc_weight import hqw_pkg::*; (
   input logic         clock,
   input logic         reset,
   hqw_req_if.sink     req_ch,
   hqw_rsp_if.source   rsp_ch,
   hqw_csr_if.sink     csr_ch
);
`include "huber_qc_weight_assert.svh"

   logic                     qc_enable_ff;
   logic signed [DATA_W-1:0] left_ff;
   logic signed [DATA_W-1:0] right_ff;
   logic                     en;

   // csr writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         qc_enable_ff <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_QC_ENABLE: qc_enable_ff <= csr_ch.wdata[0];
            CSR_LEFT:      left_ff      <= csr_ch.wdata;
            CSR_RIGHT:     right_ff     <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   logic out_valid_ff;
   assign en           = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 1: window test and magnitudes
   logic                     below_in, above_in, outside_in, neg_in;
   logic signed [DATA_W-1:0] c_in;
   logic [DATA_W-1:0]        ax_in, ac_in;
   logic                     s1_valid_ff, s1_outside_ff, s1_bad_ff;
   logic [DATA_W-1:0]        s1_ax_ff, s1_ac_ff;

   always_comb begin
      below_in   = req_ch.innovation < left_ff;
      above_in   = req_ch.innovation > right_ff;
      outside_in = qc_enable_ff && (below_in || above_in);
      c_in       = below_in ? left_ff : right_ff;
      ax_in      = req_ch.innovation[DATA_W-1] ? DATA_W'(-req_ch.innovation)
                                               : DATA_W'(req_ch.innovation);
      ac_in      = c_in[DATA_W-1] ? DATA_W'(-c_in) : DATA_W'(c_in);
      neg_in     = (c_in != '0) && (req_ch.innovation != '0) &&
                   (c_in[DATA_W-1] != req_ch.innovation[DATA_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_outside_ff <= outside_in;
         s1_bad_ff     <= (req_ch.innovation == '0) || (req_ch.error_stddev == '0) ||
                          (!below_in && neg_in);
         s1_ax_ff      <= ax_in;
         s1_ac_ff      <= ac_in;
      end
   end

   // stage 2: products
   logic              s2_valid_ff, s2_outside_ff, s2_bad_ff;
   logic [PROD_W-1:0] s2_a_ff, s2_c2_ff, s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_outside_ff <= s1_outside_ff;
         s2_bad_ff     <= s1_bad_ff;
         s2_a_ff       <= PROD_W'(s1_ac_ff) * PROD_W'(s1_ax_ff);
         s2_c2_ff      <= PROD_W'(s1_ac_ff) * PROD_W'(s1_ac_ff);
         s2_den_ff     <= PROD_W'(s1_ax_ff) * PROD_W'(s1_ax_ff);
      end
   end

   // stage 3: numerator and result class
   logic [PROD_W-1:0] twice_in, diff_in;
   logic              lt_in;
   logic              s3_valid_ff;
   hqw_tag_type       s3_tag_ff;
   logic [PROD_W-1:0] s3_num_ff, s3_den_ff;

   always_comb begin
      twice_in = s2_a_ff << 1;
      lt_in    = twice_in < s2_c2_ff;
      diff_in  = twice_in - s2_c2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_tag_ff.one     <= !s2_outside_ff;
         s3_tag_ff.zero    <= s2_outside_ff && (s2_bad_ff || lt_in);
         s3_tag_ff.outside <= s2_outside_ff;
         s3_tag_ff.invalid <= s2_outside_ff && (s2_bad_ff || lt_in);
         s3_num_ff         <= (diff_in > s2_den_ff) ? s2_den_ff : diff_in;
         s3_den_ff         <= s2_den_ff;
      end
   end

   // divider and square root
   logic              dv_valid, sq_valid;
   hqw_tag_type       dv_tag, sq_tag;
   logic [QUOT_W-1:0] dv_q;
   logic [WEIGHT_W-1:0] sq_root;

   hqw_frac_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_tag    (s3_tag_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_q     (dv_q)
   );

   hqw_isqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_tag    (dv_tag),
      .in_q      (dv_q),
      .out_valid (sq_valid),
      .out_tag   (sq_tag),
      .out_root  (sq_root)
   );

   // output register
   logic [WEIGHT_W-1:0] weight_ff;
   logic                outside_ff, invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         weight_ff  <= sq_tag.one ? WEIGHT_ONE : (sq_tag.zero ? '0 : sq_root);
         outside_ff <= sq_tag.outside;
         invalid_ff <= sq_tag.invalid;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.weight_sqrt    = weight_ff;
   assign rsp_ch.outside_window = outside_ff;
   assign rsp_ch.invalid        = invalid_ff;

   `HQW_ASSERT_IMPLY(a_invalid_zero, clock, reset, out_valid_ff && invalid_ff, weight_ff == '0)
   `HQW_ASSERT_IMPLY(a_inside_one, clock, reset, out_valid_ff && !outside_ff, weight_ff == WEIGHT_ONE && !invalid_ff)
   `HQW_ASSERT_IMPLY(a_weight_max, clock, reset, out_valid_ff, weight_ff <= WEIGHT_ONE)
   `HQW_ASSERT_NEXT(a_stall_hold, clock, reset, s3_valid_ff && !en, s3_valid_ff)
endmodule
